### sv/ghal_pkg.sv
`default_nettype none

package ghal_pkg;

  // default build-time sizes
  localparam int NUM_TYPES_DEF = 16;
  localparam int CAPACITY_DEF  = 1024;
  localparam int GEN_BITS_DEF  = 12;

  // port field widths
  localparam int OP_W     = 2;
  localparam int TYPE_W   = 4;
  localparam int GEN_W    = 12;
  localparam int IDX_W    = 10;
  localparam int STATUS_W = 2;
  localparam int LIVE_W   = 14;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [LIVE_W-1:0] LIVE_MAX = '1;

  // front-to-back queue
  localparam int Q_DEPTH = 2;
  localparam int Q_PW    = 1;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TYPE_W-1:0] obj_type;
    logic [GEN_W-1:0]  handle_gen;
    logic [IDX_W-1:0]  slot_index;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                alive;
    logic [TYPE_W-1:0]   out_type;
    logic [GEN_W-1:0]    out_gen;
    logic [IDX_W-1:0]    out_index;
    logic [LIVE_W-1:0]   live_total;
  } rsp_t;

  // request class decided by the front end
  typedef enum logic [2:0] {
    K_ALLOC,
    K_FREE,
    K_CHECK,
    K_INVALID,
    K_NOT_FOUND,
    K_DEAD
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [TYPE_W-1:0] obj_type;
    logic [GEN_W-1:0]  handle_gen;
    logic [IDX_W-1:0]  slot_index;
  } q_item_t;

  typedef enum logic {
    BK_FETCH,
    BK_EXEC
  } back_state_t;

endpackage

`default_nettype wire

### sv/ghal_front.sv
`default_nettype none

module ghal_front #(
  parameter int NUM_TYPES = ghal_pkg::NUM_TYPES_DEF,
  parameter int CAPACITY  = ghal_pkg::CAPACITY_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_stall,
  input  wire ghal_pkg::req_t  req,
  output logic                 q_valid,
  output ghal_pkg::q_item_t    q_item,
  input  wire logic            q_pop
);
  import ghal_pkg::*;

  logic          type_ok;
  logic          handle_ok;
  q_item_t       cls;
  logic          push;

  q_item_t       qmem [Q_DEPTH];
  logic [Q_PW-1:0] wr_ptr;
  logic [Q_PW-1:0] rd_ptr;
  logic [Q_PW:0]   count;
  logic [Q_PW:0]   count_next;

  // checks that need no stored state
  always_comb begin
    type_ok   = (req.obj_type != '0) && (32'(req.obj_type) < NUM_TYPES);
    handle_ok = type_ok && (req.handle_gen != '0) && (32'(req.slot_index) < CAPACITY);
    cls.obj_type   = req.obj_type;
    cls.handle_gen = req.handle_gen;
    cls.slot_index = req.slot_index;
    unique case (req.op)
      OP_ALLOC: cls.kind = type_ok ? K_ALLOC : K_INVALID;
      OP_FREE:  cls.kind = handle_ok ? K_FREE : K_NOT_FOUND;
      OP_CHECK: cls.kind = handle_ok ? K_CHECK : K_DEAD;
      default:  cls.kind = K_INVALID;
    endcase
  end

  assign req_stall = (count == (Q_PW+1)'(Q_DEPTH));
  assign push      = req_valid && !req_stall;
  assign q_valid   = (count != '0);
  assign q_item    = qmem[rd_ptr];

  always_comb begin
    count_next = count;
    case ({push, q_pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wr_ptr] <= cls;
    end
  end

endmodule

`default_nettype wire

### sv/ghal_back.sv
`default_nettype none

module ghal_back #(
  parameter int NUM_TYPES = ghal_pkg::NUM_TYPES_DEF,
  parameter int CAPACITY  = ghal_pkg::CAPACITY_DEF,
  parameter int GEN_BITS  = ghal_pkg::GEN_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire ghal_pkg::q_item_t q_item,
  output logic                   q_pop,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output ghal_pkg::rsp_t         rsp
);
  import ghal_pkg::*;

  localparam int TW        = $clog2(NUM_TYPES);
  localparam int IW        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int HW        = $clog2(CAPACITY + 1);
  localparam int GB        = GEN_BITS;
  localparam int AW        = TW + IW;
  localparam int MEM_DEPTH = NUM_TYPES * (2 ** IW);
  localparam logic [HW-1:0] NIL = HW'(CAPACITY);

  back_state_t state;
  back_state_t state_next;

  // slot stores, contents undefined until written
  logic [GB-1:0] gen_mem  [MEM_DEPTH];
  logic [HW-1:0] link_mem [MEM_DEPTH];

  logic [HW-1:0]     head [NUM_TYPES];
  logic [HW-1:0]     used [NUM_TYPES];
  logic [LIVE_W-1:0] live;

  q_item_t       cur;
  logic [GB-1:0] gen_rd;
  logic [HW-1:0] link_rd;
  logic [HW-1:0] h_cur;
  logic [HW-1:0] u_cur;

  logic          fetch;
  logic          exec_fire;
  logic [TW-1:0] qt;
  logic [IW-1:0] rd_slot;
  logic [AW-1:0] rd_addr;

  logic [TW-1:0]     t_sel;
  logic [GB-1:0]     g_cmp;
  logic              match;
  logic              got;
  logic [IW-1:0]     wr_slot;
  logic [AW-1:0]     wr_addr;
  logic [GB-1:0]     new_gen;
  logic              gen_we;
  logic              link_we;
  logic              head_we;
  logic [HW-1:0]     head_val;
  logic              used_we;
  logic [LIVE_W-1:0] live_next;
  rsp_t              res;

  // fetch side: one read of the per-type registers and the slot stores
  assign fetch   = (state == BK_FETCH) && q_valid;
  assign q_pop   = fetch;
  assign qt      = TW'(q_item.obj_type);
  assign rd_slot = (q_item.kind == K_ALLOC) ? IW'(head[qt]) : IW'(q_item.slot_index);
  assign rd_addr = {qt, rd_slot};

  assign exec_fire = (state == BK_EXEC) && (!rsp_valid || !rsp_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_FETCH: if (q_valid) begin
        state_next = BK_EXEC;
      end
      BK_EXEC: if (exec_fire) begin
        state_next = BK_FETCH;
      end
      default: state_next = BK_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_FETCH;
    end else begin
      state <= state_next;
    end
  end

  // execute side
  assign t_sel   = TW'(cur.obj_type);
  assign g_cmp   = GB'(cur.handle_gen);
  assign match   = (32'(cur.slot_index) < 32'(u_cur)) && (gen_rd == g_cmp);
  assign wr_addr = {t_sel, wr_slot};

  always_comb begin
    got       = 1'b0;
    wr_slot   = IW'(cur.slot_index);
    new_gen   = GB'(1);
    gen_we    = 1'b0;
    link_we   = 1'b0;
    head_we   = 1'b0;
    head_val  = NIL;
    used_we   = 1'b0;
    live_next = live;
    res       = '0;
    unique case (cur.kind)
      K_ALLOC: begin
        if (h_cur < NIL) begin
          // pop the free list
          got      = 1'b1;
          wr_slot  = IW'(h_cur);
          head_we  = 1'b1;
          head_val = (link_rd > NIL) ? NIL : link_rd;
          gen_we   = (gen_rd == '0);
          new_gen  = (gen_rd == '0) ? GB'(1) : gen_rd;
        end else if (u_cur < NIL) begin
          // first use of a fresh slot
          got     = 1'b1;
          wr_slot = IW'(u_cur);
          used_we = 1'b1;
          gen_we  = 1'b1;
          new_gen = GB'(1);
        end else begin
          res.status = ST_NO_SPACE;
        end
        if (got) begin
          res.out_type  = cur.obj_type;
          res.out_gen   = GEN_W'(new_gen);
          res.out_index = IDX_W'(wr_slot);
          if (live != LIVE_MAX) begin
            live_next = live + 1'b1;
          end
        end
      end
      K_FREE: begin
        if (match) begin
          new_gen = gen_rd + GB'(1);
          if (new_gen == '0) begin
            new_gen = GB'(1);
          end
          gen_we   = 1'b1;
          link_we  = 1'b1;
          head_we  = 1'b1;
          head_val = HW'(cur.slot_index);
          if (live != '0) begin
            live_next = live - 1'b1;
          end
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      K_CHECK:     res.alive  = match;
      K_INVALID:   res.status = ST_INVALID;
      K_NOT_FOUND: res.status = ST_NOT_FOUND;
      K_DEAD:      res.alive  = 1'b0;
      default:     res.status = ST_INVALID;
    endcase
    res.live_total = live_next;
  end

  always_ff @(posedge clk) begin
    if (exec_fire && gen_we) begin
      gen_mem[wr_addr] <= new_gen;
    end
    if (fetch) begin
      gen_rd <= gen_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire && link_we) begin
      link_mem[wr_addr] <= h_cur;
    end
    if (fetch) begin
      link_rd <= link_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (fetch) begin
      cur   <= q_item;
      h_cur <= head[qt];
      u_cur <= used[qt];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_TYPES; k++) begin
        head[k] <= NIL;
        used[k] <= '0;
      end
      live      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (exec_fire) begin
        if (head_we) begin
          head[t_sel] <= head_val;
        end
        if (used_we) begin
          used[t_sel] <= u_cur + 1'b1;
        end
        live      <= live_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      rsp <= res;
    end
  end

endmodule

`default_nettype wire

### sv/generational_handle_allocator_top.sv
// Path: a request is written into the queue, the back end fetches it (slot store read),
//   then executes it into the output register; responses are registered.
// The back end alternates fetch and execute, so it takes a new transaction only after the last one
//   has executed (read-then-write of the slot stores and the per-type list heads).
// Reset (rst, synchronous): all free lists empty, no slots used, live count zero,
//   queue empty; slot stores are not cleared and need no clearing pass.
`default_nettype none

module generational_handle_allocator_top #(
  parameter int NUM_TYPES = ghal_pkg::NUM_TYPES_DEF,
  parameter int CAPACITY  = ghal_pkg::CAPACITY_DEF,
  parameter int GEN_BITS  = ghal_pkg::GEN_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  // request channel
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire ghal_pkg::req_t req,
  // response channel
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output ghal_pkg::rsp_t      rsp
);
  import ghal_pkg::*;

  // classified requests waiting for the back end
  logic    q_valid;
  logic    q_pop;
  q_item_t q_item;

  // Front end: decodes the op and does every check that needs no stored
  // state (type range, zero generation, index beyond capacity), then parks
  // the transaction in a two-entry queue. It keeps taking requests, until
  // the queue is full, while the back end waits on a stalled response.
  ghal_front #(
    .NUM_TYPES (NUM_TYPES),
    .CAPACITY  (CAPACITY)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // Back end: fetch reads the slot stores (at the list head for an
  // allocate, at the handle's slot otherwise) and the type's head and used
  // count; execute updates them, adjusts the live count and loads the
  // response register.
  ghal_back #(
    .NUM_TYPES (NUM_TYPES),
    .CAPACITY  (CAPACITY),
    .GEN_BITS  (GEN_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

### sv/ghal_checker.sv
`default_nettype none

module ghal_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_stall,
  input wire logic           rsp_valid,
  input wire logic           rsp_stall,
  input wire ghal_pkg::rsp_t rsp
);
  import ghal_pkg::*;

  // response held while stalled
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // nothing pending and queue free straight after reset
  a_reset_clean: assert property (@(posedge clk)
    rst |=> !rsp_valid && !req_stall)
    else $error("state left over after reset");

  // only a successful allocate names a new handle
  a_handle_only_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |->
      (rsp.out_type == '0) && (rsp.out_gen == '0) && (rsp.out_index == '0) && !rsp.alive)
    else $error("handle fields set on a failed request");

  // a new handle never carries type none or generation zero
  a_handle_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.out_type != '0) |-> (rsp.out_gen != '0) && !rsp.alive)
    else $error("allocated handle malformed");

  // a request waiting on a full queue sees a known stall
  a_req_seen: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |-> !$isunknown(req_stall))
    else $error("request stall unknown");

endmodule

bind generational_handle_allocator_top ghal_checker u_ghal_checker (.*);

`default_nettype wire
